// ===== rtl/rssc_pkg.sv =====
package rssc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int DBM_W  = 8;
    localparam int QUAL_W = 7;
    localparam int DIV_STEPS = 7;

    localparam logic [1:0] CFG_MIN_LEVEL = 2'd0;
    localparam logic [1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [1:0] CFG_HUE_MODE  = 2'd2;

    localparam logic [DBM_W-1:0] MIN_LEVEL_RESET = 8'h9C;
    localparam logic [DBM_W-1:0] MAX_LEVEL_RESET = 8'hCE;

    localparam logic [QUAL_W-1:0] QUALITY_MAX = 7'd100;
    localparam logic [14:0] PERCENT_SCALE = 15'd100;

    localparam logic [16:0] HUE_RECIP   = 17'd1230;
    localparam logic [14:0] TENTH_RECIP = 15'd205;
    localparam logic [6:0]  HUE_SECTOR  = 7'd60;
    localparam logic [6:0]  HUE_FULL    = 7'd120;
    localparam logic [9:0]  HUE_SLOPE   = 10'd17;

    localparam logic [3:0] BAR_POINTS   = 4'd10;
    localparam logic [3:0] YELLOW_LIMIT = 4'd7;
    localparam logic [7:0] CHAN_FULL    = 8'd255;
    localparam logic [7:0] CHAN_GRAY    = 8'd100;
    localparam logic [7:0] CHAN_OFF     = 8'd0;

    typedef struct packed {
        logic [DBM_W-1:0] min_level_dbm;
        logic [DBM_W-1:0] max_level_dbm;
        logic             hue_mode;
    } t_cfg;

    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              hue_mode;
    } t_entry;

endpackage

// ===== rtl/rssc_fifo.sv =====
module rssc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/rssc_front.sv =====
module rssc_front
    import rssc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_push,
    output logic             o_full,
    input  logic [DBM_W-1:0] i_rssi_dbm,
    output logic             o_q_push,
    output t_entry           o_q_data,
    input  logic             i_q_full
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_PUSH = 4'b1000
    } t_state;

    t_state            r_state;
    logic [6:0]        r_diff;
    logic [7:0]        r_div;
    logic [14:0]       r_rem;
    logic [14:0]       r_dsh;
    logic [2:0]        r_step;
    logic [QUAL_W-1:0] r_quot;
    logic              r_mode;

    logic [8:0]  w_lo;
    logic [8:0]  w_hi;
    logic [8:0]  w_span;
    logic        w_at_min;
    logic        w_at_max;
    logic        w_take;
    logic        w_fits;

    assign w_lo   = {i_rssi_dbm[7], i_rssi_dbm} - {i_cfg.min_level_dbm[7], i_cfg.min_level_dbm};
    assign w_hi   = {i_rssi_dbm[7], i_rssi_dbm} - {i_cfg.max_level_dbm[7], i_cfg.max_level_dbm};
    assign w_span = {i_cfg.max_level_dbm[7], i_cfg.max_level_dbm}
                  - {i_cfg.min_level_dbm[7], i_cfg.min_level_dbm};
    assign w_at_min = w_lo[8] || (w_lo == '0);
    assign w_at_max = !w_hi[8];
    assign w_take   = i_push && (r_state == S_IDLE);
    assign w_fits   = (r_rem >= r_dsh);

    assign o_full   = (r_state != S_IDLE);
    assign o_q_push = (r_state == S_PUSH) && !i_q_full;
    assign o_q_data = '{quality: r_quot, hue_mode: r_mode};

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_diff <= w_lo[6:0];
            r_div  <= w_span[7:0];
            r_mode <= i_cfg.hue_mode;
        end
        case (r_state)
            S_IDLE: begin
                if (w_at_min) begin
                    r_quot <= '0;
                end else begin
                    r_quot <= QUALITY_MAX;
                end
            end
            S_MUL: begin
                r_rem  <= {8'b0, r_diff} * PERCENT_SCALE;
                r_dsh  <= {1'b0, r_div, 6'b0};
                r_step <= 3'(DIV_STEPS - 1);
                r_quot <= '0;
            end
            S_DIV: begin
                if (w_fits) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_quot <= {r_quot[QUAL_W-2:0], w_fits};
                r_dsh  <= r_dsh >> 1;
                r_step <= r_step - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_state <= (w_at_min || w_at_max) ? S_PUSH : S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/rssc_back.sv =====
module rssc_back
    import rssc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_entry     i_q_data,
    output logic       o_q_pop,
    output logic       o_empty,
    input  logic       i_pop,
    output logic [3:0] o_height_step,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic       o_last
);

    logic       r_act;
    logic       r_mode;
    logic [6:0] r_h;
    logic [3:0] r_n;
    logic [3:0] r_idx;
    logic       r_valid;

    logic [16:0] w_hprod;
    logic [14:0] w_nprod;
    logic        w_emit;
    logic        w_last;
    logic        w_load;
    logic [6:0]  w_m;
    logic [9:0]  w_rise;
    logic [9:0]  w_fall;
    logic [3:0]  n_height;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    assign w_hprod = {10'b0, i_q_data.quality} * HUE_RECIP;
    assign w_nprod = {8'b0, i_q_data.quality} * TENTH_RECIP;

    assign w_emit  = r_act && (!r_valid || i_pop);
    assign w_last  = r_mode || (r_idx == BAR_POINTS);
    assign w_load  = !r_act || (w_emit && w_last);
    assign o_q_pop = w_load && !i_q_empty;
    assign o_empty = !r_valid;

    assign w_m    = (r_h >= HUE_SECTOR) ? r_h - HUE_SECTOR : r_h;
    assign w_rise = ({3'b0, w_m} * HUE_SLOPE) >> 2;
    assign w_fall = ({3'b0, HUE_SECTOR - w_m} * HUE_SLOPE) >> 2;

    always_comb begin
        n_height = '0;
        n_red    = CHAN_FULL;
        n_green  = CHAN_OFF;
        n_blue   = CHAN_OFF;
        if (r_mode) begin
            if (r_h < HUE_SECTOR) begin
                n_green = w_rise[7:0];
            end else if (r_h < HUE_FULL) begin
                n_red   = w_fall[7:0];
                n_green = CHAN_FULL;
            end else begin
                n_red   = CHAN_OFF;
                n_green = CHAN_FULL;
            end
        end else if (r_idx < BAR_POINTS) begin
            n_height = r_idx + 1'b1;
            if (r_idx < r_n) begin
                n_red   = (r_idx < YELLOW_LIMIT) ? CHAN_FULL : CHAN_OFF;
                n_green = CHAN_FULL;
            end else begin
                n_red   = CHAN_GRAY;
                n_green = CHAN_GRAY;
                n_blue  = CHAN_GRAY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mode <= i_q_data.hue_mode;
            r_h    <= w_hprod[16:10];
            r_n    <= w_nprod[14:11];
        end
        if (w_emit) begin
            o_height_step <= n_height;
            o_red         <= n_red;
            o_green       <= n_green;
            o_blue        <= n_blue;
            o_last        <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (w_emit && w_last) begin
                r_act <= 1'b0;
            end else if (w_emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/rssi_signal_symbol_color.sv =====
// Maps a signal strength in dBm to a quality from 0 to 100 between the
// programmed minimum and maximum levels and emits colored points from it:
// one hue point in hue mode, or ten bar points followed by a red anchor point
// in bar mode. The front end takes one item and computes the quality with a
// bit-serial divider, skipping the divider when the value is clamped at
// either level. The back end drives one point per cycle while its output is
// popped, so in hue mode the divider sets the pace. A small queue between the
// two lets the front end work on the next item while the back end still
// drives points.
module rssi_signal_symbol_color
    import rssc_pkg::*;
#(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [DBM_W-1:0] i_cfg_data,
    input  logic             i_push,
    output logic             o_full,
    input  logic [DBM_W-1:0] i_rssi_dbm,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [3:0]       o_height_step,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_last
);

    t_cfg   r_cfg;
    t_entry w_fe_data;
    t_entry w_be_data;
    logic   w_fe_push;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_be_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_level_dbm <= MIN_LEVEL_RESET;
            r_cfg.max_level_dbm <= MAX_LEVEL_RESET;
            r_cfg.hue_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MIN_LEVEL: r_cfg.min_level_dbm <= i_cfg_data;
                CFG_MAX_LEVEL: r_cfg.max_level_dbm <= i_cfg_data;
                CFG_HUE_MODE:  r_cfg.hue_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rssc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_rssi_dbm (i_rssi_dbm),
        .o_q_push   (w_fe_push),
        .o_q_data   (w_fe_data),
        .i_q_full   (w_q_full)
    );

    rssc_fifo #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fe_push),
        .i_data  (w_fe_data),
        .o_full  (w_q_full),
        .i_pop   (w_be_pop),
        .o_data  (w_be_data),
        .o_empty (w_q_empty)
    );

    rssc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_data      (w_be_data),
        .o_q_pop       (w_be_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_height_step (o_height_step),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last        (o_last)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
    import rssc_pkg::*;
();

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 31;

    typedef struct packed {
        logic [3:0] height;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_color_point;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_index;
    logic [DBM_W-1:0] i_cfg_data;
    logic             i_push = 1'b0;
    logic             o_full;
    logic [DBM_W-1:0] i_rssi_dbm = '0;
    logic             o_empty;
    logic             i_pop = 1'b0;
    logic [3:0]       o_height_step;
    logic [7:0]       o_red;
    logic [7:0]       o_green;
    logic [7:0]       o_blue;
    logic             o_last;

    logic signed [7:0] lvl_min;
    logic signed [7:0] lvl_max;
    logic              hue_on;

    logic [DBM_W-1:0] pending_dbm[$];
    t_color_point     expected_points[$];
    t_color_point     want;

    int send_idle_pct;
    int take_idle_pct;
    int send_gap;
    int take_gap;
    int stall_cycles;
    int errors = 0;
    int items_sent = 0;
    int points_seen = 0;
    int settings_used;

    rssi_signal_symbol_color u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_rssi_dbm    (i_rssi_dbm),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_height_step (o_height_step),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int rssi_quality(logic signed [7:0] dbm);
        if (dbm <= lvl_min) return 0;
        if (dbm >= lvl_max) return 100;
        return ((int'(dbm) - int'(lvl_min)) * 100) / (int'(lvl_max) - int'(lvl_min));
    endfunction

    function automatic t_color_point make_point(int h, int r, int g, int b, int l);
        t_color_point p;
        p.height = 4'(h);
        p.red    = 8'(r);
        p.green  = 8'(g);
        p.blue   = 8'(b);
        p.last   = 1'(l);
        return p;
    endfunction

    function automatic void append_point(t_color_point p);
        expected_points.insert(expected_points.size(), p);
    endfunction

    function automatic void queue_points_for(logic [7:0] dbm);
        int q;
        int hue;
        int m;
        int n;
        q = rssi_quality($signed(dbm));
        if (hue_on) begin
            hue = q * 120 / 100;
            m = hue % 60;
            if (hue < 60)
                append_point(make_point(0, 255, 255 * m / 60, 0, 1));
            else if (hue < 120)
                append_point(make_point(0, 255 * (60 - m) / 60, 255, 0, 1));
            else
                append_point(make_point(0, 0, 255, 0, 1));
        end else begin
            n = q / 10;
            for (int i = 0; i < 10; i++) begin
                if (i < n)
                    append_point(make_point(i + 1, (i < 7) ? 255 : 0, 255, 0, 0));
                else
                    append_point(make_point(i + 1, 100, 100, 100, 0));
            end
            append_point(make_point(0, 255, 0, 0, 1));
        end
    endfunction

    function automatic int draw_gap(int pct);
        if (int'($urandom_range(0, 99)) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(20, 60));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic void add_item(int dbm);
        pending_dbm.insert(pending_dbm.size(), 8'(dbm));
    endfunction

    function automatic int pick_dbm();
        int lo;
        int hi;
        if ($urandom_range(0, 3) == 0) return -int'($urandom_range(0, 128));
        lo = ((lvl_min < lvl_max) ? int'(lvl_min) : int'(lvl_max)) - 3;
        hi = ((lvl_min < lvl_max) ? int'(lvl_max) : int'(lvl_min)) + 3;
        if (lo < -128) lo = -128;
        if (hi > 0) hi = 0;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
        end
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        case (index)
            CFG_MIN_LEVEL: lvl_min = data;
            CFG_MAX_LEVEL: lvl_max = data;
            CFG_HUE_MODE:  hue_on  = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_levels(input int lo, input int hi, input logic hue);
        cfg_write(CFG_MIN_LEVEL, 8'(lo));
        cfg_write(CFG_MAX_LEVEL, 8'(hi));
        cfg_write(CFG_HUE_MODE, {7'd0, hue});
        settings_used++;
    endtask

    task automatic drain();
        while (pending_dbm.size() != 0 || expected_points.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_push && !o_full) begin
                queue_points_for(pending_dbm.pop_front());
                items_sent++;
                send_gap = draw_gap(send_idle_pct);
            end
            if (send_gap > 0 || pending_dbm.size() == 0) begin
                if (send_gap > 0) send_gap--;
                i_push <= 1'b0;
            end else begin
                i_push     <= 1'b1;
                i_rssi_dbm <= pending_dbm[0];
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
            take_gap = 0;
        end else begin
            if (i_pop && !o_empty) begin
                points_seen++;
                if (expected_points.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected point, height %0d rgb %0d %0d %0d last %0d",
                             $time, o_height_step, o_red, o_green, o_blue, o_last);
                end else begin
                    want = expected_points.pop_front();
                    check_field("height_step", want.height, o_height_step);
                    check_field("red", want.red, o_red);
                    check_field("green", want.green, o_green);
                    check_field("blue", want.blue, o_blue);
                    check_field("last", want.last, o_last);
                end
                take_gap = draw_gap(take_idle_pct);
            end
            if (take_gap > 0) begin
                take_gap--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)
            || (pending_dbm.size() == 0 && expected_points.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("rssi_signal_symbol_color test failed");
                $finish;
            end
        end
    end

    initial begin
        int a;
        int b;
        int t;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_MIN_LEVEL;
        i_cfg_data    = '0;
        lvl_min       = -8'sd100;
        lvl_max       = -8'sd50;
        hue_on        = 1'b0;
        send_idle_pct = 30;
        take_idle_pct = 30;
        settings_used = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset levels in bar mode: clamps, the bar edges and the green section.
        @(negedge i_clk);
        add_item(-128); add_item(0); add_item(-100); add_item(-99);
        add_item(-50); add_item(-51); add_item(-56); add_item(-95);
        drain();

        // Hue mode across every sector, with a write to the unused index.
        cfg_write(CFG_HUE_MODE, 8'd1);
        cfg_write(CFG_SPARE, 8'h7F);
        @(negedge i_clk);
        add_item(-100); add_item(-99); add_item(-80); add_item(-75);
        add_item(-60); add_item(-51); add_item(0);
        drain();

        // Widest span, then inverted and equal levels that only clamp.
        set_levels(-128, 0, 1'b1);
        @(negedge i_clk);
        add_item(-128); add_item(-127); add_item(-1); add_item(-64);
        drain();
        set_levels(-10, -20, 1'b0);
        @(negedge i_clk);
        add_item(-10); add_item(-9); add_item(-128);
        drain();
        set_levels(-60, -60, 1'b1);
        @(negedge i_clk);
        add_item(-60); add_item(-59);
        drain();
        set_levels(0, -128, 1'b1);
        @(negedge i_clk);
        add_item(0); add_item(-1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            a = -int'($urandom_range(0, 128));
            b = -int'($urandom_range(0, 128));
            if ($urandom_range(0, 4) != 0 && a > b) begin
                t = a;
                a = b;
                b = t;
            end
            set_levels(a, b, p[0]);
            send_idle_pct = (p == 0) ? 0 : ((p == 1) ? 60 : 25);
            take_idle_pct = (p == 0) ? 0 : ((p == 1) ? 60 : 25);
            @(negedge i_clk);
            for (int k = 0; k < PHASE_ITEMS; k++)
                add_item(pick_dbm());
            drain();
        end

        repeat (40) @(posedge i_clk);
        $display("Sent %0d items and checked %0d points over %0d level settings,",
                 items_sent, points_seen, settings_used);
        $display("covering bar and hue modes, clamped, inverted and interpolated levels.");
        if (errors == 0)
            $display("rssi_signal_symbol_color test passed");
        else
            $display("rssi_signal_symbol_color test failed");
        $finish;
    end

endmodule
